/* rtl/iee_pkg.sv */
// Shared types, constants and helpers of the infix expression evaluator.
// Used by the controller, the datapath and the top level; no dependencies.
package iee_pkg;

   localparam int OPD_DEPTH = 32;
   localparam int OPR_DEPTH = 32;
   localparam int OPD_CNT_W = $clog2(OPD_DEPTH + 1);
   localparam int OPR_CNT_W = $clog2(OPR_DEPTH + 1);
   localparam int OPD_IDX_W = $clog2(OPD_DEPTH);
   localparam int OPR_IDX_W = $clog2(OPR_DEPTH);

   localparam logic [7:0] CH_MUL   = 8'h2A;
   localparam logic [7:0] CH_DIV   = 8'h2F;
   localparam logic [7:0] CH_ADD   = 8'h2B;
   localparam logic [7:0] CH_SUB   = 8'h2D;
   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   typedef enum logic [2:0] {
      OP_OPEN = 3'd0,
      OP_ADD  = 3'd1,
      OP_SUB  = 3'd2,
      OP_MUL  = 3'd3,
      OP_DIV  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_CLOSE    = 3'd1,
      ST_OPEN     = 3'd2,
      ST_MISSING  = 3'd3,
      ST_DIVZERO  = 3'd4,
      ST_OVERFLOW = 3'd5
   } stat_type;

   typedef enum logic [2:0] {
      CC_DIGIT,
      CC_OPEN,
      CC_CLOSE,
      CC_OPER,
      CC_OTHER
   } char_class_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_LOOP,
      S_OP_USE,
      S_RED_START,
      S_RED_RD2,
      S_RED_EXEC,
      S_RED_DIV,
      S_RED_WB,
      S_END,
      S_FIN_CHECK,
      S_FIN_EMIT
   } state_type;

   typedef enum logic [1:0] {
      MODE_CLOSE,
      MODE_OPER,
      MODE_FINAL
   } mode_type;

   typedef struct packed {
      logic     load_char;
      logic     push_digit;
      logic     push_op;
      logic     pop_op;
      logic     latch_op;
      logic     rd_next;
      logic     latch_right;
      logic     alu_latch;
      logic     div_start;
      logic     div_latch;
      logic     write_result;
      logic     set_err;
      stat_type err_code;
      logic     emit;
   } dp_cmd_type;

   typedef struct packed {
      char_class_type cls;
      logic           last;
      logic           err_nz;
      logic           opr_empty;
      logic           opr_full;
      logic           opd_full;
      logic           opd_lt2;
      logic           opd_empty;
      logic           top_is_open;
      logic           rank_ge;
      op_type         red_op;
      logic           right_zero;
      logic           div_done;
      logic           out_busy;
   } dp_status_type;

   function automatic logic [1:0] rank_of(input op_type op);
      logic [1:0] r;
      case (op)
         OP_MUL, OP_DIV: r = 2'd2;
         OP_ADD, OP_SUB: r = 2'd1;
         default:        r = 2'd0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/iee_divider.sv */
// Iterative signed 32-bit divider, truncating toward zero, one quotient bit a cycle.
// Depends on nothing but its ports.
module iee_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  count_ff, count_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] mb_ff, mb_in;
   logic        neg_ff, neg_in;
   logic [32:0] shifted;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      mb_in    = mb_ff;
      neg_in   = neg_ff;
      shifted  = {rem_ff, quo_ff[31]};
      if (start) begin
         busy_in  = 1'b1;
         count_in = 5'd0;
         rem_in   = 32'd0;
         quo_in   = dividend[31] ? (32'd0 - dividend) : dividend;
         mb_in    = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in   = dividend[31] ^ divisor[31];
      end else if (busy_ff) begin
         if (shifted >= {1'b0, mb_ff}) begin
            rem_in = 32'(shifted - {1'b0, mb_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = shifted[31:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      mb_ff    <= mb_in;
      neg_ff   <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;

endmodule

/* rtl/iee_datapath.sv */
// Datapath: operand and operator stacks, counters, error latch, ALU and result register.
// Depends on iee_pkg and iee_divider.
module iee_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            char_code,
   input  logic                  last_char,
   input  iee_pkg::dp_cmd_type   cmd,
   output iee_pkg::dp_status_type status,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_value,
   output logic [2:0]            rsp_status
);
   import iee_pkg::*;

   logic [31:0] opd_mem [OPD_DEPTH];
   op_type      opr_mem [OPR_DEPTH];

   logic [7:0]           char_ff;
   logic                 last_ff;
   logic [OPD_CNT_W-1:0] opd_cnt_ff, opd_cnt_in;
   logic [OPR_CNT_W-1:0] opr_cnt_ff, opr_cnt_in;
   stat_type             err_ff, err_in;
   logic [31:0]          opd_rd_ff;
   op_type               opr_rd_ff;
   op_type               red_op_ff;
   logic [31:0]          right_ff;
   logic [31:0]          result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_value_ff;
   stat_type             rsp_status_ff;

   logic [OPD_CNT_W-1:0] opd_top, opd_next;
   logic [OPR_CNT_W-1:0] opr_top;
   logic [OPD_IDX_W-1:0] opd_rd_addr;
   op_type               in_op;
   char_class_type       cls;
   logic                 div_done;
   logic [31:0]          div_q;
   logic [63:0]          product;

   assign opd_top  = opd_cnt_ff - OPD_CNT_W'(1);
   assign opd_next = opd_cnt_ff - OPD_CNT_W'(2);
   assign opr_top  = opr_cnt_ff - OPR_CNT_W'(1);
   assign opd_rd_addr = cmd.rd_next ? opd_next[OPD_IDX_W-1:0] : opd_top[OPD_IDX_W-1:0];

   always_comb begin
      in_op = OP_OPEN;
      cls   = CC_OTHER;
      if (char_ff >= CH_ZERO && char_ff <= CH_NINE) begin
         cls = CC_DIGIT;
      end else begin
         case (char_ff)
            CH_OPEN:  cls = CC_OPEN;
            CH_CLOSE: cls = CC_CLOSE;
            CH_ADD: begin
               cls = CC_OPER; in_op = OP_ADD;
            end
            CH_SUB: begin
               cls = CC_OPER; in_op = OP_SUB;
            end
            CH_MUL: begin
               cls = CC_OPER; in_op = OP_MUL;
            end
            CH_DIV: begin
               cls = CC_OPER; in_op = OP_DIV;
            end
            default: cls = CC_OTHER;
         endcase
      end
   end

   iee_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (opd_rd_ff),
      .divisor  (right_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign product = opd_rd_ff * right_ff;

   always_comb begin
      result_in = result_ff;
      if (cmd.alu_latch) begin
         case (red_op_ff)
            OP_ADD:  result_in = opd_rd_ff + right_ff;
            OP_SUB:  result_in = opd_rd_ff - right_ff;
            default: result_in = product[31:0];
         endcase
      end else if (cmd.div_latch) begin
         result_in = div_q;
      end
   end

   always_comb begin
      opd_cnt_in = opd_cnt_ff;
      opr_cnt_in = opr_cnt_ff;
      err_in     = err_ff;
      if (cmd.push_digit)   opd_cnt_in = opd_cnt_ff + OPD_CNT_W'(1);
      if (cmd.write_result) opd_cnt_in = opd_cnt_ff - OPD_CNT_W'(1);
      if (cmd.push_op)      opr_cnt_in = opr_cnt_ff + OPR_CNT_W'(1);
      if (cmd.pop_op)       opr_cnt_in = opr_cnt_ff - OPR_CNT_W'(1);
      if (cmd.set_err && err_ff == ST_OK) err_in = cmd.err_code;
      if (cmd.emit) begin
         opd_cnt_in = '0;
         opr_cnt_in = '0;
         err_in     = ST_OK;
      end
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.emit)  rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         opd_cnt_ff   <= '0;
         opr_cnt_ff   <= '0;
         err_ff       <= ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         opd_cnt_ff   <= opd_cnt_in;
         opr_cnt_ff   <= opr_cnt_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_char) begin
         char_ff <= char_code;
         last_ff <= last_char;
      end
      if (cmd.latch_op)    red_op_ff <= opr_rd_ff;
      if (cmd.latch_right) right_ff  <= opd_rd_ff;
      result_ff <= result_in;
      if (cmd.emit) begin
         rsp_value_ff  <= (err_ff == ST_OK) ? opd_rd_ff : 32'd0;
         rsp_status_ff <= err_ff;
      end
   end

   // Operand stack: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push_digit)
         opd_mem[opd_cnt_ff[OPD_IDX_W-1:0]] <= {24'd0, 8'(char_ff - CH_ZERO)};
      else if (cmd.write_result)
         opd_mem[opd_next[OPD_IDX_W-1:0]] <= result_ff;
      opd_rd_ff <= opd_mem[opd_rd_addr];
   end

   // Operator stack: the read port always looks at the top entry.
   always_ff @(posedge clock) begin
      if (cmd.push_op)
         opr_mem[opr_cnt_ff[OPR_IDX_W-1:0]] <= (cls == CC_OPEN) ? OP_OPEN : in_op;
      opr_rd_ff <= opr_mem[opr_top[OPR_IDX_W-1:0]];
   end

   always_comb begin
      status.cls         = cls;
      status.last        = last_ff;
      status.err_nz      = (err_ff != ST_OK);
      status.opr_empty   = (opr_cnt_ff == '0);
      status.opr_full    = (opr_cnt_ff == OPR_CNT_W'(OPR_DEPTH));
      status.opd_full    = (opd_cnt_ff == OPD_CNT_W'(OPD_DEPTH));
      status.opd_lt2     = (opd_cnt_ff < OPD_CNT_W'(2));
      status.opd_empty   = (opd_cnt_ff == '0);
      status.top_is_open = (opr_rd_ff == OP_OPEN);
      status.rank_ge     = (rank_of(opr_rd_ff) >= rank_of(in_op));
      status.red_op      = red_op_ff;
      status.right_zero  = (right_ff == 32'd0);
      status.div_done    = div_done;
      status.out_busy    = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;

endmodule

/* rtl/iee_ctrl.sv */
// Controller state machine: sequences decode, reduction loops and result emission.
// Depends on iee_pkg; drives the datapath through dp_cmd_type.
module iee_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  iee_pkg::dp_status_type status,
   output iee_pkg::dp_cmd_type    cmd
);
   import iee_pkg::*;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_FINAL;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.err_code = ST_OK;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_char = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_END;
            if (!status.err_nz) begin
               case (status.cls)
                  CC_DIGIT: begin
                     if (status.opd_full) begin
                        cmd.set_err = 1'b1; cmd.err_code = ST_OVERFLOW;
                     end else cmd.push_digit = 1'b1;
                  end
                  CC_OPEN: begin
                     if (status.opr_full) begin
                        cmd.set_err = 1'b1; cmd.err_code = ST_OVERFLOW;
                     end else cmd.push_op = 1'b1;
                  end
                  CC_CLOSE: begin
                     mode_in = MODE_CLOSE; state_in = S_LOOP;
                  end
                  CC_OPER: begin
                     mode_in = MODE_OPER; state_in = S_LOOP;
                  end
                  default: state_in = S_END;
               endcase
            end
         end
         S_LOOP: begin
            // Top operator is read here and shows up in S_OP_USE.
            if (status.err_nz) begin
               state_in = (mode_ff == MODE_FINAL) ? S_FIN_CHECK : S_END;
            end else if (status.opr_empty) begin
               unique case (mode_ff)
                  MODE_CLOSE: begin
                     cmd.set_err = 1'b1; cmd.err_code = ST_CLOSE; state_in = S_END;
                  end
                  MODE_OPER: begin
                     if (status.opr_full) begin
                        cmd.set_err = 1'b1; cmd.err_code = ST_OVERFLOW;
                     end else cmd.push_op = 1'b1;
                     state_in = S_END;
                  end
                  default: state_in = S_FIN_CHECK;
               endcase
            end else begin
               state_in = S_OP_USE;
            end
         end
         S_OP_USE: begin
            cmd.latch_op = 1'b1;
            state_in = S_RED_START;
            if (mode_ff == MODE_CLOSE && status.top_is_open) begin
               cmd.pop_op = 1'b1;
               state_in = S_END;
            end else if (mode_ff == MODE_OPER && !status.rank_ge) begin
               if (status.opr_full) begin
                  cmd.set_err = 1'b1; cmd.err_code = ST_OVERFLOW;
               end else cmd.push_op = 1'b1;
               state_in = S_END;
            end
         end
         S_RED_START: begin
            if (status.opd_lt2) begin
               cmd.set_err = 1'b1; cmd.err_code = ST_MISSING; state_in = S_END;
            end else state_in = S_RED_RD2;
         end
         S_RED_RD2: begin
            // Right operand arrives; fetch the left one.
            cmd.latch_right = 1'b1;
            cmd.rd_next = 1'b1;
            state_in = S_RED_EXEC;
         end
         S_RED_EXEC: begin
            cmd.rd_next = 1'b1;
            case (status.red_op)
               OP_OPEN: begin
                  cmd.set_err = 1'b1; cmd.err_code = ST_OPEN; state_in = S_END;
               end
               OP_DIV: begin
                  if (status.right_zero) begin
                     cmd.set_err = 1'b1; cmd.err_code = ST_DIVZERO; state_in = S_END;
                  end else begin
                     cmd.div_start = 1'b1; state_in = S_RED_DIV;
                  end
               end
               default: begin
                  cmd.alu_latch = 1'b1; state_in = S_RED_WB;
               end
            endcase
         end
         S_RED_DIV: begin
            if (status.div_done) begin
               cmd.div_latch = 1'b1; state_in = S_RED_WB;
            end
         end
         S_RED_WB: begin
            cmd.write_result = 1'b1;
            cmd.pop_op = 1'b1;
            state_in = S_LOOP;
         end
         S_END: begin
            if (status.last) begin
               mode_in = MODE_FINAL; state_in = S_LOOP;
            end else state_in = S_IDLE;
         end
         S_FIN_CHECK: begin
            if (!status.err_nz && status.opd_empty) begin
               cmd.set_err = 1'b1; cmd.err_code = ST_MISSING;
            end
            state_in = S_FIN_EMIT;
         end
         S_FIN_EMIT: begin
            // Hold until the output register frees up.
            if (!status.out_busy) begin
               cmd.emit = 1'b1; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/infix_expression_evaluator.sv */
// Top level of the infix expression evaluator: controller plus datapath.
// Depends on iee_pkg, iee_ctrl, iee_datapath and iee_divider.
//
// Takes one ASCII character per transfer and works on it before taking the next.
// A digit, an opening parenthesis or a skipped character is handled in decode alone;
// an operator or a closing parenthesis also runs the reduction loop, in which each
// reduction reads its two operands in turn through the single read port of the operand
// stack and a division waits on the one-bit-per-cycle divider. The last character also
// runs the final reductions and loads the result register, which the next character can
// pass while the result waits to be taken.
// Status 0 is ok; on any error the value is 0 and only the first error is kept.
module infix_expression_evaluator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_code,
   input  logic               req_last_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value,
   output logic [2:0]         rsp_status
);
   import iee_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   iee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   iee_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .char_code  (req_char_code),
      .last_char  (req_last_char),
      .cmd        (cmd),
      .status     (status),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_value  (rsp_value),
      .rsp_status (rsp_status)
   );

endmodule
